// ===== rtl/core/aes128_key_expansion_defines.svh =====
// Assertion macros for the AES-128 key expansion block.
`ifndef AES128_KEY_EXPANSION_DEFINES_SVH
`define AES128_KEY_EXPANSION_DEFINES_SVH

`ifndef SYNTHESIS

`define AKX_ASSERT_IMPL(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

`define AKX_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AKX_ASSERT_IMPL(label, clock, reset, ante, cons, msg)

`define AKX_ASSERT_NEXT(label, clock, reset, ante, cons, msg)

`endif

`endif

// ===== rtl/core/aes_kx_pkg.sv =====
// Package: types, constants and tables of the AES-128 key expansion.
`timescale 1ns / 1ps

package aes_kx_pkg;

  localparam int HALF_W    = 64;
  localparam int WORD_W    = 32;
  localparam int NUM_WORDS = 4;
  localparam int ROUND_W   = 4;

  localparam logic [ROUND_W-1:0] NUM_ROUNDS = 4'd10;

  typedef struct packed {
    logic load;
    logic adv;
  } cell_ctrl_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constant used to build round r+1 from round r.
  function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
    logic [7:0] c;
    case (r)
      4'd0:    c = 8'h01;
      4'd1:    c = 8'h02;
      4'd2:    c = 8'h04;
      4'd3:    c = 8'h08;
      4'd4:    c = 8'h10;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h40;
      4'd7:    c = 8'h80;
      4'd8:    c = 8'h1b;
      4'd9:    c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/aes_kx_if.sv =====
// Valid/ready channel interfaces for cipher keys and round keys.
`timescale 1ns / 1ps

interface aes_kx_key_if;
  import aes_kx_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] key_upper;
  logic [HALF_W-1:0] key_lower;

  modport source (output valid, output key_upper, output key_lower, input ready);
  modport sink   (input valid, input key_upper, input key_lower, output ready);
endinterface

interface aes_kx_rkey_if;
  import aes_kx_pkg::*;

  logic               valid;
  logic               ready;
  logic [ROUND_W-1:0] round_number;
  logic [HALF_W-1:0]  round_key_upper;
  logic [HALF_W-1:0]  round_key_lower;
  logic               final_round;

  modport source (output valid, output round_number, output round_key_upper,
                  output round_key_lower, output final_round, input ready);
  modport sink   (input valid, input round_number, input round_key_upper,
                  input round_key_lower, input final_round, output ready);
endinterface

// ===== rtl/core/aes_kx_word_cell.sv =====
// One 32-bit word of the round key register; XOR chain link to the next word.
`timescale 1ns / 1ps

module aes_kx_word_cell (
  input  logic                          clk,
  input  aes_kx_pkg::cell_ctrl_t        ctrl,
  input  logic [aes_kx_pkg::WORD_W-1:0] load_word,
  input  logic [aes_kx_pkg::WORD_W-1:0] chain_in,
  output logic [aes_kx_pkg::WORD_W-1:0] word,
  output logic [aes_kx_pkg::WORD_W-1:0] word_next
);
  import aes_kx_pkg::*;

  assign word_next = word ^ chain_in;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= load_word;
    end else if (ctrl.adv) begin
      word <= word_next;
    end
  end

endmodule

// ===== rtl/core/aes_kx_rot_sub.sv =====
// RotWord, SubWord and round constant applied to the last word of a round key.
`timescale 1ns / 1ps

module aes_kx_rot_sub (
  input  logic [aes_kx_pkg::WORD_W-1:0]  word,
  input  logic [aes_kx_pkg::ROUND_W-1:0] rnd,
  output logic [aes_kx_pkg::WORD_W-1:0]  temp
);
  import aes_kx_pkg::*;

  logic [WORD_W-1:0] sub;

  assign sub = {SBOX[word[23:16]], SBOX[word[15:8]], SBOX[word[7:0]], SBOX[word[31:24]]};
  assign temp = sub ^ {rcon(rnd), 24'h000000};

endmodule

// ===== rtl/core/aes128_key_expansion.sv =====
// AES-128 key expansion: cipher key in, eleven round keys out in round order.
`timescale 1ns / 1ps
`include "aes128_key_expansion_defines.svh"

// Each cipher key beat produces 11 round-key beats, rounds 0 to 10, with
// final_round set on round 10. Round 0 is loaded into the word cells when
// the key is accepted and then moves to the output register; later rounds
// follow one per cycle while the output is not stalled. The round register
// is a row of four word cells that computes one round per cycle while not
// stalled; it hands round 10 to the output register in the same cycle it
// loads the next key, so keys stream back to back. No state is kept between keys.
module aes128_key_expansion (
  input  logic                 clk,
  input  logic                 rst,
  aes_kx_key_if.sink           cipher_key,
  aes_kx_rkey_if.source        round_key
);
  import aes_kx_pkg::*;

  logic               busy;
  logic [ROUND_W-1:0] rnd;
  logic               out_valid;
  logic [ROUND_W-1:0] out_round;
  logic [HALF_W-1:0]  out_upper;
  logic [HALF_W-1:0]  out_lower;
  logic               out_final;

  logic       move;
  logic       last;
  logic       acc;
  cell_ctrl_t ctrl;

  logic [WORD_W-1:0] key_words  [NUM_WORDS];
  logic [WORD_W-1:0] words      [NUM_WORDS];
  logic [WORD_W-1:0] words_next [NUM_WORDS];
  logic [WORD_W-1:0] chain      [NUM_WORDS];
  logic [WORD_W-1:0] temp;

  assign move = busy && (!out_valid || round_key.ready);
  assign last = (rnd == NUM_ROUNDS);
  assign cipher_key.ready = !busy || (move && last);
  assign acc = cipher_key.valid && cipher_key.ready;

  assign ctrl.load = acc;
  assign ctrl.adv  = move && !last;

  assign key_words[0] = cipher_key.key_upper[HALF_W-1:WORD_W];
  assign key_words[1] = cipher_key.key_upper[WORD_W-1:0];
  assign key_words[2] = cipher_key.key_lower[HALF_W-1:WORD_W];
  assign key_words[3] = cipher_key.key_lower[WORD_W-1:0];

  aes_kx_rot_sub u_rot_sub (
    .word (words[NUM_WORDS-1]),
    .rnd  (rnd),
    .temp (temp)
  );

  assign chain[0] = temp;

  for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign chain[i] = words_next[i-1];
    end
    aes_kx_word_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_word (key_words[i]),
      .chain_in  (chain[i]),
      .word      (words[i]),
      .word_next (words_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (acc) begin
      busy <= 1'b1;
      rnd  <= '0;
    end else if (move && last) begin
      busy <= 1'b0;
    end else if (move) begin
      rnd <= rnd + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (round_key.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_round <= rnd;
      out_upper <= {words[0], words[1]};
      out_lower <= {words[2], words[3]};
      out_final <= last;
    end
  end

  assign round_key.valid           = out_valid;
  assign round_key.round_number    = out_round;
  assign round_key.round_key_upper = out_upper;
  assign round_key.round_key_lower = out_lower;
  assign round_key.final_round     = out_final;

  `AKX_ASSERT_NEXT(a_load_round0, clk, rst, acc, busy && rnd == 4'd0, "key load not at round 0")
  `AKX_ASSERT_IMPL(a_round_range, clk, rst, busy, rnd <= NUM_ROUNDS, "round counter out of range")
  `AKX_ASSERT_IMPL(a_next_round, clk, rst, out_valid && !out_final,
                   busy && rnd == out_round + 4'd1, "round register out of step with output")
  `AKX_ASSERT_IMPL(a_final_flag, clk, rst, out_valid,
                   out_final == (out_round == NUM_ROUNDS) && out_round <= NUM_ROUNDS,
                   "final flag disagrees with round number")

endmodule
